FILE: design/bounding_sphere_merge_macros.svh
// assertion macros for the bounding sphere merge block
// used by bounding_sphere_merge.sv, expects aclk and aresetn in scope
`ifndef BOUNDING_SPHERE_MERGE_MACROS_SVH
`define BOUNDING_SPHERE_MERGE_MACROS_SVH
`ifndef SYNTH
`define BSM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bounding_sphere_merge assertion failed");
`define BSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bounding_sphere_merge assertion failed");
`else
`define BSM_ASSERT_IMPL(lbl, ante, cons)
`define BSM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: design/bsm_pkg.sv
// shared widths and transaction types for the bounding sphere merge block
// no dependencies
package bsm_pkg;

    localparam int CW   = 24;
    localparam int RW   = CW - 1;
    localparam int RADW = CW + 1;
    localparam int GROW = 2 * RADW;

    typedef struct packed {
        logic signed [CW-1:0] a_center_x;
        logic signed [CW-1:0] a_center_y;
        logic signed [CW-1:0] a_center_z;
        logic        [RW-1:0] a_radius;
        logic signed [CW-1:0] b_center_x;
        logic signed [CW-1:0] b_center_y;
        logic signed [CW-1:0] b_center_z;
        logic        [RW-1:0] b_radius;
    } bsm_in_t;

    typedef struct packed {
        logic signed [CW-1:0]   merged_x;
        logic signed [CW-1:0]   merged_y;
        logic signed [CW-1:0]   merged_z;
        logic        [RADW-1:0] merged_radius;
        logic        [GROW-1:0] growth;
        logic                   overlaps;
    } bsm_out_t;

endpackage

FILE: design/bounding_sphere_merge.sv
// bounding sphere merge top level: enclosing sphere, growth and overlap test
// depends on bsm_pkg and bounding_sphere_merge_macros.svh
//
// Takes one sphere pair per cycle and returns one result per pair, in order.
// The pipeline holds, in order: input capture, differences, squares and
// compares, CW+1 stages of a one-bit-per-stage square root, the radius and
// product stages, the divider load stage, CW stages of a restoring divider
// (one quotient bit per stage, three coordinates in parallel) and the output
// register. A stall on the result channel holds the whole pipeline.
`include "bounding_sphere_merge_macros.svh"
module bounding_sphere_merge
    import bsm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  bsm_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output bsm_out_t m_data
);

    localparam int DSW   = 2 * CW + 2;
    localparam int QW    = CW + 1;
    localparam int REMW  = QW + 2;
    localparam int PW    = CW + RADW;
    localparam int DREMW = CW + 2;

    typedef struct packed {
        logic [2:0][CW-1:0] ca;
        logic [2:0][CW-1:0] cb;
        logic [2:0][CW-1:0] mag;
        logic [2:0]         neg;
        logic [RW-1:0]      ra;
        logic [RW-1:0]      rb;
        logic               abig;
        logic               contain;
        logic               ovl;
    } side_t;

    logic en;
    assign en = !m_valid || m_ready;
    assign s_ready = en;

    // stage 1: captured inputs
    logic               s1_vld_reg;
    logic [2:0][CW-1:0] s1_ca_reg, s1_cb_reg;
    logic [RW-1:0]      s1_ra_reg, s1_rb_reg;

    // stage 2: magnitudes
    logic          s2_vld_reg;
    side_t         s2_side_reg, s2_side_next;
    logic [RW-1:0] s2_rd_reg, s2_rd_next;
    logic [CW-1:0] s2_ovs_reg, s2_ovs_next;

    // stage 3: squares
    logic                 s3_vld_reg;
    side_t                s3_side_reg;
    logic [2:0][2*CW-1:0] s3_sq_reg, s3_sq_next;
    logic [2*RW-1:0]      s3_rdsq_reg, s3_rdsq_next;
    logic [2*CW-1:0]      s3_ovsq_reg, s3_ovsq_next;

    // square root stages
    logic            sq_vld_reg  [QW+1];
    side_t           sq_side_reg [QW+1];
    side_t           sq_side_next[QW+1];
    logic [DSW-1:0]  sq_x_reg    [QW+1];
    logic [DSW-1:0]  sq_x_next   [QW+1];
    logic [REMW-1:0] sq_rem_reg  [QW+1];
    logic [REMW-1:0] sq_rem_next [QW+1];
    logic [QW-1:0]   sq_root_reg [QW+1];
    logic [QW-1:0]   sq_root_next[QW+1];

    // radius stage
    logic            rd_vld_reg;
    side_t           rd_side_reg;
    logic [QW-1:0]   rd_d_reg;
    logic [RADW-1:0] rd_radius_reg, rd_radius_next;
    logic [RADW-1:0] rd_step_reg, rd_step_next;

    // product stage
    logic              mu_vld_reg;
    side_t             mu_side_reg;
    logic [QW-1:0]     mu_d_reg;
    logic [RADW-1:0]   mu_radius_reg;
    logic [2:0][PW-1:0] mu_prod_reg, mu_prod_next;
    logic [GROW-1:0]   mu_rsq_reg, mu_rsq_next;
    logic [2*RW-1:0]   mu_rasq_reg, mu_rasq_next;

    // divider stages
    logic                  dv_vld_reg    [CW+1];
    side_t                 dv_side_reg   [CW+1];
    logic [QW-1:0]         dv_d_reg      [CW+1];
    logic [RADW-1:0]       dv_radius_reg [CW+1];
    logic [GROW-1:0]       dv_growth_reg [CW+1];
    logic [2:0][PW-1:0]    dv_prod_reg   [CW+1];
    logic [2:0][DREMW-1:0] dv_rem_reg    [CW+1];
    logic [2:0][DREMW-1:0] dv_rem_next   [CW+1];
    logic [2:0][CW-1:0]    dv_quo_reg    [CW+1];
    logic [2:0][CW-1:0]    dv_quo_next   [CW+1];

    // output register
    logic     out_vld_reg;
    bsm_out_t out_data_reg, out_data_next;

    assign m_valid = out_vld_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        logic signed [CW:0] dc;
        logic [DSW-1:0]     dist2;
        logic [REMW-1:0]    cur;
        logic [REMW-1:0]    trial;
        logic [QW:0]        rsum;
        logic [DREMW-1:0]   dcur;
        logic [DREMW-1:0]   dext;
        logic [2:0][CW-1:0] ctr;
        side_t              fs;
        logic [CW-1:0]      q;

        s2_side_next = '0;
        for (int i = 0; i < 3; i++) begin
            dc = $signed({s1_cb_reg[i][CW-1], s1_cb_reg[i]})
               - $signed({s1_ca_reg[i][CW-1], s1_ca_reg[i]});
            s2_side_next.neg[i] = dc[CW];
            s2_side_next.mag[i] = dc[CW] ? CW'(-dc) : dc[CW-1:0];
        end
        s2_side_next.ca   = s1_ca_reg;
        s2_side_next.cb   = s1_cb_reg;
        s2_side_next.ra   = s1_ra_reg;
        s2_side_next.rb   = s1_rb_reg;
        s2_side_next.abig = s1_ra_reg > s1_rb_reg;
        s2_rd_next  = (s1_ra_reg > s1_rb_reg) ? s1_ra_reg - s1_rb_reg : s1_rb_reg - s1_ra_reg;
        s2_ovs_next = {1'b0, s1_ra_reg} + {1'b0, s1_rb_reg};

        for (int i = 0; i < 3; i++) begin
            s3_sq_next[i] = {{CW{1'b0}}, s2_side_reg.mag[i]}
                          * {{CW{1'b0}}, s2_side_reg.mag[i]};
        end
        s3_rdsq_next = {{RW{1'b0}}, s2_rd_reg} * {{RW{1'b0}}, s2_rd_reg};
        s3_ovsq_next = {{CW{1'b0}}, s2_ovs_reg} * {{CW{1'b0}}, s2_ovs_reg};

        dist2 = {2'b00, s3_sq_reg[0]} + {2'b00, s3_sq_reg[1]} + {2'b00, s3_sq_reg[2]};
        sq_side_next[0]         = s3_side_reg;
        sq_side_next[0].contain = {{(DSW-2*RW){1'b0}}, s3_rdsq_reg} >= dist2;
        sq_side_next[0].ovl     = dist2 <= {2'b00, s3_ovsq_reg};
        sq_x_next[0]    = dist2;
        sq_rem_next[0]  = '0;
        sq_root_next[0] = '0;

        for (int k = 0; k < QW; k++) begin
            cur   = {sq_rem_reg[k][REMW-3:0], sq_x_reg[k][DSW-1-2*k -: 2]};
            trial = {sq_root_reg[k], 2'b01};
            sq_side_next[k+1] = sq_side_reg[k];
            sq_x_next[k+1]    = sq_x_reg[k];
            if (cur >= trial) begin
                sq_rem_next[k+1]  = cur - trial;
                sq_root_next[k+1] = {sq_root_reg[k][QW-2:0], 1'b1};
            end else begin
                sq_rem_next[k+1]  = cur;
                sq_root_next[k+1] = {sq_root_reg[k][QW-2:0], 1'b0};
            end
        end

        rsum = {1'b0, sq_root_reg[QW]} + {2'b00, sq_side_reg[QW].ra}
             + {2'b00, sq_side_reg[QW].rb};
        if (sq_side_reg[QW].contain) begin
            rd_radius_next = sq_side_reg[QW].abig ? {2'b00, sq_side_reg[QW].ra}
                                                  : {2'b00, sq_side_reg[QW].rb};
        end else begin
            rd_radius_next = rsum[QW:1];
        end
        rd_step_next = rd_radius_next - {2'b00, sq_side_reg[QW].ra};

        for (int i = 0; i < 3; i++) begin
            mu_prod_next[i] = {{RADW{1'b0}}, rd_side_reg.mag[i]} * {{CW{1'b0}}, rd_step_reg};
        end
        mu_rsq_next  = {{RADW{1'b0}}, rd_radius_reg} * {{RADW{1'b0}}, rd_radius_reg};
        mu_rasq_next = {{RW{1'b0}}, rd_side_reg.ra} * {{RW{1'b0}}, rd_side_reg.ra};

        for (int i = 0; i < 3; i++) begin
            dv_rem_next[0][i] = {1'b0, mu_prod_reg[i][PW-1:CW]};
            dv_quo_next[0][i] = '0;
        end
        for (int k = 0; k < CW; k++) begin
            dext = {1'b0, dv_d_reg[k]};
            for (int i = 0; i < 3; i++) begin
                dcur = {dv_rem_reg[k][i][DREMW-2:0], dv_prod_reg[k][i][CW-1-k]};
                if (dcur >= dext) begin
                    dv_rem_next[k+1][i] = dcur - dext;
                    dv_quo_next[k+1][i] = {dv_quo_reg[k][i][CW-2:0], 1'b1};
                end else begin
                    dv_rem_next[k+1][i] = dcur;
                    dv_quo_next[k+1][i] = {dv_quo_reg[k][i][CW-2:0], 1'b0};
                end
            end
        end

        fs = dv_side_reg[CW];
        for (int i = 0; i < 3; i++) begin
            q = dv_quo_reg[CW][i];
            if (fs.contain) begin
                ctr[i] = fs.abig ? fs.ca[i] : fs.cb[i];
            end else if (fs.neg[i]) begin
                ctr[i] = fs.ca[i] - q;
            end else begin
                ctr[i] = fs.ca[i] + q;
            end
        end
        out_data_next.merged_x      = ctr[0];
        out_data_next.merged_y      = ctr[1];
        out_data_next.merged_z      = ctr[2];
        out_data_next.merged_radius = dv_radius_reg[CW];
        out_data_next.growth        = dv_growth_reg[CW];
        out_data_next.overlaps      = fs.ovl;
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            rd_vld_reg  <= 1'b0;
            mu_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int k = 0; k <= QW; k++) sq_vld_reg[k] <= 1'b0;
            for (int k = 0; k <= CW; k++) dv_vld_reg[k] <= 1'b0;
        end else if (en) begin
            s1_vld_reg    <= s_valid;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            sq_vld_reg[0] <= s3_vld_reg;
            for (int k = 0; k < QW; k++) sq_vld_reg[k+1] <= sq_vld_reg[k];
            rd_vld_reg    <= sq_vld_reg[QW];
            mu_vld_reg    <= rd_vld_reg;
            dv_vld_reg[0] <= mu_vld_reg;
            for (int k = 0; k < CW; k++) dv_vld_reg[k+1] <= dv_vld_reg[k];
            out_vld_reg   <= dv_vld_reg[CW];
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_ca_reg <= {s_data.a_center_z, s_data.a_center_y, s_data.a_center_x};
            s1_cb_reg <= {s_data.b_center_z, s_data.b_center_y, s_data.b_center_x};
            s1_ra_reg <= s_data.a_radius;
            s1_rb_reg <= s_data.b_radius;

            s2_side_reg <= s2_side_next;
            s2_rd_reg   <= s2_rd_next;
            s2_ovs_reg  <= s2_ovs_next;

            s3_side_reg <= s2_side_reg;
            s3_sq_reg   <= s3_sq_next;
            s3_rdsq_reg <= s3_rdsq_next;
            s3_ovsq_reg <= s3_ovsq_next;

            for (int k = 0; k <= QW; k++) begin
                sq_side_reg[k] <= sq_side_next[k];
                sq_x_reg[k]    <= sq_x_next[k];
                sq_rem_reg[k]  <= sq_rem_next[k];
                sq_root_reg[k] <= sq_root_next[k];
            end

            rd_side_reg   <= sq_side_reg[QW];
            rd_d_reg      <= sq_root_reg[QW];
            rd_radius_reg <= rd_radius_next;
            rd_step_reg   <= rd_step_next;

            mu_side_reg   <= rd_side_reg;
            mu_d_reg      <= rd_d_reg;
            mu_radius_reg <= rd_radius_reg;
            mu_prod_reg   <= mu_prod_next;
            mu_rsq_reg    <= mu_rsq_next;
            mu_rasq_reg   <= mu_rasq_next;

            dv_side_reg[0]   <= mu_side_reg;
            dv_d_reg[0]      <= mu_d_reg;
            dv_radius_reg[0] <= mu_radius_reg;
            dv_growth_reg[0] <= mu_rsq_reg - {{(GROW-2*RW){1'b0}}, mu_rasq_reg};
            dv_prod_reg[0]   <= mu_prod_reg;
            for (int k = 0; k < CW; k++) begin
                dv_side_reg[k+1]   <= dv_side_reg[k];
                dv_d_reg[k+1]      <= dv_d_reg[k];
                dv_radius_reg[k+1] <= dv_radius_reg[k];
                dv_growth_reg[k+1] <= dv_growth_reg[k];
                dv_prod_reg[k+1]   <= dv_prod_reg[k];
            end
            for (int k = 0; k <= CW; k++) begin
                dv_rem_reg[k] <= dv_rem_next[k];
                dv_quo_reg[k] <= dv_quo_next[k];
            end

            out_data_reg <= out_data_next;
        end
    end

    `BSM_ASSERT_IMPL(a_stall_blocks_input, m_valid && !m_ready, !s_ready)
    `BSM_ASSERT_IMPL(a_radius_not_below_a, rd_vld_reg, rd_radius_reg >= {2'b00, rd_side_reg.ra})
    `BSM_ASSERT_IMPL(a_root_bound, sq_vld_reg[QW], ({{QW{1'b0}}, sq_root_reg[QW]} * {{QW{1'b0}}, sq_root_reg[QW]}) <= sq_x_reg[QW])

endmodule

FILE: dv/tb.sv
// self-checking testbench for bounding_sphere_merge: directed table, then random sphere pairs
// predicts each merged sphere in-line and scoreboards m_data; depends on bsm_pkg
module tb;
    import bsm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 2 * CW + 9;
    localparam int N_RANDOM = 1000;
    localparam longint CYCLE_LIMIT = 400000;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    bsm_in_t  s_data;
    logic     m_valid;
    logic     m_ready = 1'b0;
    bsm_out_t m_data;

    bounding_sphere_merge u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    typedef struct {
        bsm_in_t  pair;
        bit       typed;
        bsm_out_t want;
    } pair_row_t;

    bsm_out_t  merge_queue[$];
    int        mismatch_count = 0;
    int        table_error_count = 0;
    int        sender_idle_pct;
    int        receiver_idle_pct;
    longint    cycle_count = 0;
    pair_row_t pair_table[$];

    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [RW-1:0] RMAX = {RW{1'b1}};

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic bsm_out_t merge_spheres(input bsm_in_t p);
        bsm_out_t        r;
        longint          ca[3];
        longint          cb[3];
        longint          dc[3];
        longint          mc[3];
        longint unsigned mag[3];
        longint unsigned ra, rb, dist2, rd, radius, d, step, q, rsum;
        longint unsigned gr;
        ca[0] = p.a_center_x; ca[1] = p.a_center_y; ca[2] = p.a_center_z;
        cb[0] = p.b_center_x; cb[1] = p.b_center_y; cb[2] = p.b_center_z;
        ra = p.a_radius;
        rb = p.b_radius;
        dist2 = 0;
        for (int i = 0; i < 3; i++) begin
            dc[i] = cb[i] - ca[i];
            mag[i] = dc[i] < 0 ? -dc[i] : dc[i];
            dist2 += mag[i] * mag[i];
        end
        rd = ra > rb ? ra - rb : rb - ra;
        if (rd * rd >= dist2) begin
            radius = ra > rb ? ra : rb;
            for (int i = 0; i < 3; i++) mc[i] = ra > rb ? ca[i] : cb[i];
        end else begin
            d = int_sqrt(dist2);
            radius = (d + ra + rb) >> 1;
            step = radius - ra;
            for (int i = 0; i < 3; i++) begin
                mc[i] = ca[i];
                if (d != 0) begin
                    q = (mag[i] * step) / d;
                    mc[i] = dc[i] < 0 ? mc[i] - longint'(q) : mc[i] + longint'(q);
                end
            end
        end
        rsum = ra + rb;
        gr = radius * radius - ra * ra;
        r.merged_x = mc[0][CW-1:0];
        r.merged_y = mc[1][CW-1:0];
        r.merged_z = mc[2][CW-1:0];
        r.merged_radius = radius[RADW-1:0];
        r.growth = gr[GROW-1:0];
        r.overlaps = dist2 <= rsum * rsum;
        return r;
    endfunction

    function automatic bsm_in_t make_pair(input longint ax, ay, az, ar, bx, by, bz, br);
        bsm_in_t p;
        p.a_center_x = ax[CW-1:0]; p.a_center_y = ay[CW-1:0]; p.a_center_z = az[CW-1:0];
        p.a_radius = ar[RW-1:0];
        p.b_center_x = bx[CW-1:0]; p.b_center_y = by[CW-1:0]; p.b_center_z = bz[CW-1:0];
        p.b_radius = br[RW-1:0];
        return p;
    endfunction

    function automatic bsm_out_t make_result(input longint x, y, z, rad, gr, input bit ov);
        bsm_out_t r;
        r.merged_x = x[CW-1:0]; r.merged_y = y[CW-1:0]; r.merged_z = z[CW-1:0];
        r.merged_radius = rad[RADW-1:0];
        r.growth = gr[GROW-1:0];
        r.overlaps = ov;
        return r;
    endfunction

    function automatic bsm_in_t random_pair();
        bsm_in_t    p;
        int         mode;
        bit [191:0] rnd;
        mode = $urandom_range(0, 3);
        rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        p = rnd[$bits(bsm_in_t)-1:0];
        if (mode == 1) begin
            // nearby pair, mostly the merge branch with small offsets
            p.b_center_x = p.a_center_x + $signed(CW'($urandom_range(0, 8191)) - CW'(4096));
            p.b_center_y = p.a_center_y + $signed(CW'($urandom_range(0, 8191)) - CW'(4096));
            p.b_center_z = p.a_center_z + $signed(CW'($urandom_range(0, 8191)) - CW'(4096));
            p.a_radius = RW'($urandom_range(0, 8191));
            p.b_radius = RW'($urandom_range(0, 8191));
        end else if (mode == 2) begin
            // containment and equal radii
            p.b_center_x = p.a_center_x + $signed(CW'($urandom_range(0, 15)));
            p.b_center_y = p.a_center_y;
            p.b_center_z = p.a_center_z;
            if ($urandom_range(0, 1)) p.b_radius = p.a_radius;
        end
        return p;
    endfunction

    task automatic send_pair(input bsm_in_t p, input bsm_out_t want);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        merge_queue.push_back(want);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            m_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    always @(posedge aclk) begin
        bsm_out_t want;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_valid && m_ready) begin
            if (merge_queue.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10) $display("unexpected result transaction %p", m_data);
            end else begin
                want = merge_queue.pop_front();
                if (m_data !== want) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("mismatch: expected %p actual %p", want, m_data);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bounding_sphere_merge test failed");
            $finish;
        end
    end

    initial begin
        bsm_in_t p;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        pair_table.push_back('{make_pair(0, 0, 0, 0, 0, 0, 0, 0), 1,
                               make_result(0, 0, 0, 0, 0, 1)});
        pair_table.push_back('{make_pair(5, 6, 7, 100, 5, 6, 7, 100), 1,
                               make_result(5, 6, 7, 100, 0, 1)});
        pair_table.push_back('{make_pair(0, 0, 0, 4096, 0, 0, 0, 8192), 1,
                               make_result(0, 0, 0, 8192, 50331648, 1)});
        pair_table.push_back('{make_pair(0, 0, 0, 8192, 0, 0, 0, 4096), 1,
                               make_result(0, 0, 0, 8192, 0, 1)});
        pair_table.push_back('{make_pair(0, 0, 0, 0, 100, 0, 0, 0), 1,
                               make_result(50, 0, 0, 50, 2500, 0)});
        pair_table.push_back('{make_pair(CMIN, CMIN, CMIN, 0, CMAX, CMAX, CMAX, 0), 0, '0});
        pair_table.push_back('{make_pair(CMAX, CMIN, CMAX, RMAX, CMIN, CMAX, CMIN, RMAX), 0, '0});
        pair_table.push_back('{make_pair(CMIN, CMIN, CMIN, RMAX, CMIN, CMIN, CMIN, 0), 0, '0});
        pair_table.push_back('{make_pair(CMAX, CMAX, CMAX, 0, CMAX, CMAX, CMAX, RMAX), 0, '0});
        pair_table.push_back('{make_pair(0, 0, 0, 100, 200, 0, 0, 100), 0, '0});
        pair_table.push_back('{make_pair(0, 0, 0, 100, 201, 0, 0, 100), 0, '0});
        pair_table.push_back('{make_pair(-1, -1, -1, 1, 1, 1, 1, 1), 0, '0});
        pair_table.push_back('{make_pair(0, 0, 0, 10, 3, 4, 0, 5), 0, '0});
        pair_table.push_back('{make_pair(0, 0, 0, 5, 3, 4, 0, 10), 0, '0});
        pair_table.push_back('{make_pair(-7, 3, 9, 0, 12, -40, 5, 3), 0, '0});
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (pair_table[i]) begin
            if (pair_table[i].typed && merge_spheres(pair_table[i].pair) != pair_table[i].want) begin
                table_error_count = table_error_count + 1;
                $display("directed row %0d predictor disagrees with table", i);
            end
            if (pair_table[i].typed) begin
                send_pair(pair_table[i].pair, pair_table[i].want);
            end else begin
                send_pair(pair_table[i].pair, merge_spheres(pair_table[i].pair));
            end
        end
        for (int ph = 0; ph < 3; ph++) begin
            sender_idle_pct   = ph == 0 ? 29 : (ph == 1 ? 58 : 0);
            receiver_idle_pct = ph == 0 ? 58 : (ph == 1 ? 29 : 0);
            for (int n = 0; n < N_RANDOM / 3; n++) begin
                p = random_pair();
                send_pair(p, merge_spheres(p));
            end
        end
        s_valid <= 1'b0;
        receiver_idle_pct = 0;
        while (merge_queue.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (mismatch_count == 0 && table_error_count == 0) begin
            $display("bounding_sphere_merge test passed");
        end else begin
            $display("bounding_sphere_merge test failed");
        end
        $finish;
    end
endmodule
